>>> hw/rtl/sta_pkg.sv
// Package for the sphere texture address block: widths, CORDIC angle table
// and shared types. No dependencies.
`default_nettype none
package sta_pkg;
	localparam int MAX_SIDE_DEF  = 2048;
	localparam int FRAC_BITS_DEF = 16;
	localparam int CORDIC_STEPS  = 24;
	localparam int CW = 40;
	localparam int IDX_W = 22;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_REPEAT = 2'd2;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [31:0] ang;
	} cordic_t;

	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] t [CORDIC_STEPS] = '{
			32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
			32'd42667331, 32'd21354465, 32'd10680350, 32'd5340588,
			32'd2670983, 32'd1335855, 32'd667544, 32'd333772,
			32'd166886, 32'd83443, 32'd41721, 32'd20860,
			32'd10430, 32'd5215, 32'd2607, 32'd1303,
			32'd651, 32'd325, 32'd162, 32'd81};
		return t[i];
	endfunction
endpackage
`default_nettype wire

>>> hw/rtl/sta_cordic_stage.sv
// One registered vectoring CORDIC micro-rotation with stall support.
// Depends on sta_pkg.
`default_nettype none
module sta_cordic_stage #(
	parameter int STEP = 0
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           vin,
	input  wire sta_pkg::cordic_t din,
	output logic                vout,
	output sta_pkg::cordic_t    dout
);
	sta_pkg::cordic_t nxt;
	always_comb begin
		nxt = din;
		if (din.y > 0) begin
			nxt.x = din.x + (din.y >>> STEP);
			nxt.y = din.y - (din.x >>> STEP);
			nxt.ang = din.ang + sta_pkg::atan_turn(STEP);
		end else begin
			nxt.x = din.x - (din.y >>> STEP);
			nxt.y = din.y + (din.x >>> STEP);
			nxt.ang = din.ang - sta_pkg::atan_turn(STEP);
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vout <= 1'b0;
		else if (en) vout <= vin;
	end
	always_ff @(posedge clk) begin
		if (en) dout <= nxt;
	end
endmodule
`default_nettype wire

>>> hw/rtl/sta_cordic.sv
// Pipelined 24-stage vectoring CORDIC giving atan2 as a binary angle.
// Depends on sta_pkg and sta_cordic_stage.
`default_nettype none
module sta_cordic (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         vin,
	input  wire logic signed [sta_pkg::CW-1:0] yin,
	input  wire logic signed [sta_pkg::CW-1:0] xin,
	output logic                              vout,
	output logic [31:0]                       ang
);
	localparam int N = sta_pkg::CORDIC_STEPS;
	sta_pkg::cordic_t d [N+1];
	sta_pkg::cordic_t d0;
	logic v [N+1];
	logic zero_s [N+1];
	always_comb begin
		if (xin < 0) begin
			d0.x = -xin;
			d0.y = -yin;
			d0.ang = 32'h8000_0000;
		end else begin
			d0.x = xin;
			d0.y = yin;
			d0.ang = '0;
		end
	end
	assign d[0] = d0;
	assign v[0] = vin;
	assign zero_s[0] = (xin == 0) && (yin == 0);
	for (genvar i = 0; i < N; i++) begin : g_st
		sta_cordic_stage #(.STEP(i)) u_st (
			.clk(clk), .arst_n(arst_n), .en(en), .vin(v[i]), .din(d[i]),
			.vout(v[i+1]), .dout(d[i+1]));
		always_ff @(posedge clk) begin
			if (en) zero_s[i+1] <= zero_s[i];
		end
	end
	assign vout = v[N];
	assign ang = zero_s[N] ? 32'd0 : d[N].ang;
endmodule
`default_nettype wire

>>> hw/rtl/sta_isqrt.sv
// Pipelined 15-step restoring integer square root of 1 - y^2, carrying y.
// Depends on no package.
`default_nettype none
module sta_isqrt (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               vin,
	input  wire logic signed [15:0] yin,
	output logic                    vout,
	output logic signed [15:0]      yout,
	output logic [14:0]             root
);
	localparam int N = 15;
	logic [28:0] val [N+1];
	logic [14:0] res [N+1];
	logic signed [15:0] ys [N+1];
	logic v [N+1];
	logic signed [31:0] sq;
	assign sq = 32'(yin) * 32'(yin);
	assign val[0] = 29'(32'sd268435456 - sq);
	assign res[0] = '0;
	assign ys[0] = yin;
	assign v[0] = vin;
	for (genvar i = 0; i < N; i++) begin : g_b
		localparam int B = N - 1 - i;
		logic [14:0] t;
		logic [29:0] tt;
		assign t = res[i] | (15'd1 << B);
		assign tt = 30'(t) * 30'(t);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v[i+1] <= 1'b0;
			else if (en) v[i+1] <= v[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				val[i+1] <= val[i];
				ys[i+1] <= ys[i];
				res[i+1] <= (tt <= 30'(val[i])) ? t : res[i];
			end
		end
	end
	assign vout = v[N];
	assign yout = ys[N];
	assign root = res[N];
endmodule
`default_nettype wire

>>> hw/rtl/sta_index.sv
// Three-stage scaling of the u and v fractions into a row-major texel index.
// Depends on sta_pkg.
`default_nettype none
module sta_index #(
	parameter int FRAC_BITS = sta_pkg::FRAC_BITS_DEF,
	parameter int SIDE_W = 12
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              vin,
	input  wire logic [31:0]       lon,
	input  wire logic [31:0]       lat,
	input  wire logic [SIDE_W-1:0] w,
	input  wire logic [SIDE_W-1:0] h,
	input  wire logic [4:0]        n,
	output logic                   vout,
	output logic [sta_pkg::IDX_W-1:0] idx
);
	localparam int PW = FRAC_BITS + SIDE_W;
	logic [31:0] u32, v32;
	logic [FRAC_BITS-1:0] uf_s1, vf_s1;
	logic [PW-1:0] cp_s2, rp_s2;
	logic v1, v2, v3;
	logic [SIDE_W-1:0] row_c;
	logic [FRAC_BITS+4:0] um, vm;
	assign u32 = lon + 32'h8000_0000;
	assign v32 = 32'h8000_0000 - {lat[30:0], 1'b0};
	assign um = (FRAC_BITS+5)'(u32[31 -: FRAC_BITS]) * (FRAC_BITS+5)'(n);
	assign vm = (FRAC_BITS+5)'(v32[31 -: FRAC_BITS]) * (FRAC_BITS+5)'(n);
	assign row_c = h - SIDE_W'(1) - rp_s2[PW-1 -: SIDE_W];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
		end else if (en) begin
			v1 <= vin; v2 <= v1; v3 <= v2;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			uf_s1 <= um[FRAC_BITS-1:0];
			vf_s1 <= vm[FRAC_BITS-1:0];
			cp_s2 <= PW'(uf_s1) * PW'(w);
			rp_s2 <= PW'(vf_s1) * PW'(h);
			idx <= sta_pkg::IDX_W'(row_c) * sta_pkg::IDX_W'(w) +
				sta_pkg::IDX_W'(cp_s2[PW-1 -: SIDE_W]);
		end
	end
	assign vout = v3;
endmodule
`default_nettype wire

>>> hw/rtl/sphere_texture_address.sv
// Top level of the sphere texture address block: configuration registers,
// input clamp, CORDIC, square root and index pipelines. Depends on sta_pkg, sta_isqrt, sta_cordic and sta_index.
//
// Usage: points arrive on the s_axis channel, one beat per point, with
// tdata holding point_x, point_y and point_z. Each point yields one beat
// on m_axis carrying texel_index. The pipeline accepts one beat every cycle
// while the output is not stalled; a result passes through the input
// register, the square root stages, the 24 CORDIC stages, the index math
// and the output register.
// The latitude path runs the square root first, then its CORDIC; the
// longitude path is delayed alongside it. When the receiver stalls the
// whole pipeline holds; s_axis_tready falls only when a valid result waits.
// Reset empties the pipeline and loads width 256, height 256, repeat 1.
// Configuration writes on cfg are accepted at any time and should be made
// while the block is empty.
`default_nettype none
module sphere_texture_address #(
	parameter int MAX_SIDE  = sta_pkg::MAX_SIDE_DEF,
	parameter int FRAC_BITS = sta_pkg::FRAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,  // point_x, point_y, point_z
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // texel_index, zero fill
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [11:0] cfg_data
);
	localparam int SW = $clog2(MAX_SIDE + 1);
	logic [11:0] width_q, height_q;
	logic [4:0] rep_q;
	logic [SW-1:0] w_c, h_c;
	logic [4:0] n_c;
	logic en;
	logic signed [15:0] x_s1, y_s1, z_s1;
	logic v_s1;
	logic sq_v, lat_v, lon_v, idx_v;
	logic signed [15:0] sq_y;
	logic [14:0] sq_r;
	logic [31:0] lat_a, lon_a;
	logic [31:0] lond [15];
	logic lonv_q [15];
	logic [sta_pkg::IDX_W-1:0] idx;
	logic signed [15:0] yi, yc;

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 12'd256; height_q <= 12'd256; rep_q <= 5'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sta_pkg::REG_WIDTH:  width_q <= cfg_data;
				sta_pkg::REG_HEIGHT: height_q <= cfg_data;
				sta_pkg::REG_REPEAT: rep_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == 0) w_c = SW'(1);
		else if (32'(width_q) > MAX_SIDE) w_c = SW'(MAX_SIDE);
		else w_c = SW'(width_q);
		if (height_q == 0) h_c = SW'(1);
		else if (32'(height_q) > MAX_SIDE) h_c = SW'(MAX_SIDE);
		else h_c = SW'(height_q);
		if (rep_q == 0) n_c = 5'd1;
		else if (rep_q > 5'd16) n_c = 5'd16;
		else n_c = rep_q;
	end

	assign yi = s_axis_tdata[31:16];
	assign yc = (yi > 16'sd16384) ? 16'sd16384 : ((yi < -16'sd16384) ? -16'sd16384 : yi);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_axis_tvalid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= s_axis_tdata[15:0];
			y_s1 <= yc;
			z_s1 <= s_axis_tdata[47:32];
		end
	end

	sta_isqrt u_sqrt (.clk(clk), .arst_n(arst_n), .en(en), .vin(v_s1),
		.yin(y_s1), .vout(sq_v), .yout(sq_y), .root(sq_r));

	sta_cordic u_lon (.clk(clk), .arst_n(arst_n), .en(en), .vin(v_s1),
		.yin(sta_pkg::CW'(z_s1) <<< 14), .xin(sta_pkg::CW'(x_s1) <<< 14),
		.vout(lon_v), .ang(lon_a));

	sta_cordic u_lat (.clk(clk), .arst_n(arst_n), .en(en), .vin(sq_v),
		.yin(sta_pkg::CW'(sq_y) <<< 14),
		.xin(sta_pkg::CW'({1'b0, sq_r}) <<< 14),
		.vout(lat_v), .ang(lat_a));

	always_ff @(posedge clk) begin
		if (en) begin
			lond[0] <= lon_a;
			for (int i = 1; i < 15; i++) lond[i] <= lond[i-1];
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 15; i++) lonv_q[i] <= 1'b0;
		end else if (en) begin
			lonv_q[0] <= lon_v;
			for (int i = 1; i < 15; i++) lonv_q[i] <= lonv_q[i-1];
		end
	end

	sta_index #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SW)) u_idx (.clk(clk),
		.arst_n(arst_n), .en(en), .vin(lat_v), .lon(lond[14]), .lat(lat_a),
		.w(w_c), .h(h_c), .n(n_c), .vout(idx_v), .idx(idx));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (en) m_axis_tvalid <= idx_v;
	end
	always_ff @(posedge clk) begin
		if (en) m_axis_tdata <= {2'b00, idx};
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input blocked with empty output");
	a_lon_lat: assert property (@(posedge clk) disable iff (!arst_n)
		lat_v == lonv_q[14])
		else $error("path mismatch");
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped under stall");
endmodule
`default_nettype wire
